>>> rtl/pce_pkg.sv
// Shared types and constants for the Pearson correlation engine.
package pce_pkg;

    localparam int SUM_W   = 33;
    localparam int SQ_W    = 47;
    localparam int XY_W    = 48;
    localparam int CNT_W   = 17;
    localparam int WIDE_W  = 64;   // n*S - S*S terms, within +-2^62
    localparam int PROD_W  = 128;  // vx * vy
    localparam int ROOT_W  = 63;
    localparam int QUO_W   = 16;

    // Controller to datapath commands.
    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_TERM   = 4'd1,   // start one 32x32 partial product
        OP_ROOT   = 4'd2,   // one root bit
        OP_DIV    = 4'd3,   // one quotient bit
        OP_INIT_R = 4'd4,   // prepare root
        OP_INIT_D = 4'd5,   // prepare divide
        OP_FINISH = 4'd6    // form result
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] step;   // partial product index
        logic [5:0] bit_idx;
    } pce_cmd_t;

    typedef struct packed {
        logic two_or_more;
    } pce_sts_t;

endpackage

>>> rtl/pearson_correlation_engine.sv
// Pearson correlation engine: streams (x, y) pairs, returns r in Q1.15 on the last pair.
// Pairs are taken one per cycle while s_ready is high. The pair marked last starts a
// result sequence that ends with m_valid: 28 partial products of 32x32 bits on one
// shared multiplier for the variance and covariance terms and their 128-bit product,
// one setup step, a bit-serial square root of 63 bits, restoring division (one setup,
// fifteen quotient bits) and the forming and registering of the result. With fewer
// than two pairs the root and divide are skipped. No pair is taken until the result
// has been handed over; s_ready returns the cycle after that.
module pearson_correlation_engine
    import pce_pkg::*;
#(
    parameter int MAX_SAMPLES = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_sample_x,
    input  logic signed [15:0] s_sample_y,
    input  logic               s_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_correlation,
    output logic               m_degenerate,
    output logic [16:0]        m_sample_count,
    output logic               m_overflow
);

    pce_cmd_t cmd;
    pce_sts_t sts;
    logic     acc_en, clear;

    pce_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_last, .m_valid, .m_ready,
        .sts, .acc_en, .clear, .cmd
    );

    pce_datapath #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .aclk, .aresetn, .acc_en, .clear, .s_sample_x, .s_sample_y, .cmd, .sts,
        .res_corr(m_correlation), .res_degen(m_degenerate),
        .res_count(m_sample_count), .res_ovf(m_overflow)
    );

endmodule

>>> rtl/pce_datapath.sv
// Datapath: accumulators, wide multiply by 32-bit partial products, root and divide.
module pce_datapath
    import pce_pkg::*;
#(
    parameter int MAX_SAMPLES = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               acc_en,
    input  logic               clear,
    input  logic signed [15:0] s_sample_x,
    input  logic signed [15:0] s_sample_y,
    input  pce_cmd_t           cmd,
    output pce_sts_t           sts,
    output logic signed [15:0] res_corr,
    output logic               res_degen,
    output logic [CNT_W-1:0]   res_count,
    output logic               res_ovf
);

    logic [CNT_W-1:0]        cnt_reg;
    logic signed [SUM_W-1:0] sx_reg, sy_reg;
    logic signed [SQ_W:0]    sxx_reg, syy_reg;
    logic signed [XY_W-1:0]  sxy_reg;
    logic                    drop_reg;
    logic signed [SAMPLE_BITS-1:0] xs, ys;
    logic signed [15:0]      xe, ye;

    assign xs = s_sample_x[SAMPLE_BITS-1:0];
    assign ys = s_sample_y[SAMPLE_BITS-1:0];
    assign xe = 16'(xs);
    assign ye = 16'(ys);

    // Series accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            cnt_reg  <= '0;
            sx_reg   <= '0;
            sy_reg   <= '0;
            sxx_reg  <= '0;
            syy_reg  <= '0;
            sxy_reg  <= '0;
            drop_reg <= 1'b0;
        end else if (acc_en) begin
            if (cnt_reg < CNT_W'(MAX_SAMPLES)) begin
                cnt_reg <= cnt_reg + 1'b1;
                sx_reg  <= sx_reg + SUM_W'(xe);
                sy_reg  <= sy_reg + SUM_W'(ye);
                sxx_reg <= sxx_reg + (SQ_W+1)'(32'(xe) * 32'(xe));
                syy_reg <= syy_reg + (SQ_W+1)'(32'(ye) * 32'(ye));
                sxy_reg <= sxy_reg + XY_W'(32'(xe) * 32'(ye));
            end else begin
                drop_reg <= 1'b1;
            end
        end
    end

    assign sts.two_or_more = (cnt_reg >= CNT_W'(2));

    // Sign-extended 64-bit operands for the wide terms (count zero-extended)
    logic [WIDE_W-1:0] n64, sx64, sy64, sxx64, syy64, sxy64;
    assign n64   = WIDE_W'(cnt_reg);
    assign sx64  = WIDE_W'(sx_reg);
    assign sy64  = WIDE_W'(sy_reg);
    assign sxx64 = WIDE_W'(sxx_reg);
    assign syy64 = WIDE_W'(syy_reg);
    assign sxy64 = WIDE_W'(sxy_reg);

    // Wide terms: vx, vy, num accumulate from 32x32 partial products.
    // Step k: term t = k/4 in {vx_a,vx_b,vy_a,vy_b,num_a,num_b,pp(vx*vy)...}
    logic [WIDE_W-1:0] vx_reg, vy_reg, num_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [WIDE_W-1:0] ma, mb;
    logic [31:0]       pa, pb;
    logic [63:0]       pp_reg;
    logic [4:0]        pp_step_reg;
    logic              pp_vld_reg;

    // operand select: steps 0..3 n*sxx, 4..7 sx*sx (subtract), 8..11 n*syy,
    // 12..15 sy*sy, 16..19 n*sxy, 20..23 sx*sy, 24..27 vx*vy
    always_comb begin
        unique case (cmd.step[4:2])
            3'd0:    begin ma = n64;    mb = sxx64;  end
            3'd1:    begin ma = sx64;   mb = sx64;   end
            3'd2:    begin ma = n64;    mb = syy64;  end
            3'd3:    begin ma = sy64;   mb = sy64;   end
            3'd4:    begin ma = n64;    mb = sxy64;  end
            3'd5:    begin ma = sx64;   mb = sy64;   end
            3'd6:    begin ma = vx_reg; mb = vy_reg; end
            default: begin ma = '0;     mb = '0;     end
        endcase
        pa = cmd.step[1] ? ma[63:32] : ma[31:0];
        pb = cmd.step[0] ? mb[63:32] : mb[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pp_vld_reg <= 1'b0;
        end else begin
            pp_vld_reg <= (cmd.op == OP_TERM);
        end
        pp_reg      <= pa * pb;
        pp_step_reg <= cmd.step;
    end

    // shift of the partial product by 0, 32 or 64 bits
    logic [PROD_W-1:0] pp_sh;
    logic [WIDE_W-1:0] pp_lo;
    always_comb begin
        unique case ({pp_step_reg[1], pp_step_reg[0]})
            2'b00:   pp_sh = PROD_W'(pp_reg);
            2'b11:   pp_sh = {pp_reg, 64'd0};
            default: pp_sh = {32'd0, pp_reg, 32'd0};
        endcase
        pp_lo = pp_sh[WIDE_W-1:0];
    end

    // root and divide state
    logic [ROOT_W-1:0] root_reg;
    logic [WIDE_W-1:0] rem_reg;
    logic [QUO_W-1:0]  q_reg;
    logic              neg_reg;
    logic [ROOT_W-1:0] cand;
    logic [PROD_W-1:0] cand_sq;
    logic [PROD_W-1:0] rem2;
    logic [WIDE_W-1:0] den64;
    logic [PROD_W-1:0] sq_reg;  // root_reg^2, tracked incrementally

    // (r + 2^b)^2 = r^2 + r*2^(b+1) + 2^(2b)
    assign cand    = root_reg | (ROOT_W'(1) << cmd.bit_idx);
    assign cand_sq = sq_reg + (PROD_W'(root_reg) << (cmd.bit_idx + 6'd1))
                     + (PROD_W'(1) << {cmd.bit_idx, 1'b0});
    assign den64   = WIDE_W'(root_reg);
    assign rem2    = {63'd0, rem_reg, 1'b0};

    always_ff @(posedge aclk) begin
        if (pp_vld_reg) begin
            unique case (pp_step_reg[4:2])
                3'd0, 3'd2, 3'd4: begin
                    if (pp_step_reg[1:0] == 2'd0) begin
                        // first partial product starts the term
                        if (pp_step_reg[4:2] == 3'd0) vx_reg  <= pp_lo;
                        if (pp_step_reg[4:2] == 3'd2) vy_reg  <= pp_lo;
                        if (pp_step_reg[4:2] == 3'd4) num_reg <= pp_lo;
                    end else begin
                        if (pp_step_reg[4:2] == 3'd0) vx_reg  <= vx_reg + pp_lo;
                        if (pp_step_reg[4:2] == 3'd2) vy_reg  <= vy_reg + pp_lo;
                        if (pp_step_reg[4:2] == 3'd4) num_reg <= num_reg + pp_lo;
                    end
                end
                3'd1: vx_reg  <= vx_reg - pp_lo;
                3'd3: vy_reg  <= vy_reg - pp_lo;
                3'd5: num_reg <= num_reg - pp_lo;
                3'd6: begin
                    if (pp_step_reg[1:0] == 2'd0) prod_reg <= pp_sh;
                    else                          prod_reg <= prod_reg + pp_sh;
                end
                default: ;
            endcase
        end
        unique case (cmd.op)
            OP_INIT_R: begin
                root_reg <= '0;
                sq_reg   <= '0;
            end
            OP_ROOT: begin
                if (cand_sq <= prod_reg) begin
                    root_reg <= cand;
                    sq_reg   <= cand_sq;
                end
            end
            OP_INIT_D: begin
                neg_reg <= num_reg[WIDE_W-1];
                if ((num_reg[WIDE_W-1] ? (~num_reg + 1'b1) : num_reg) >= den64) begin
                    q_reg   <= QUO_W'(1);
                    rem_reg <= (num_reg[WIDE_W-1] ? (~num_reg + 1'b1) : num_reg) - den64;
                end else begin
                    q_reg   <= '0;
                    rem_reg <= num_reg[WIDE_W-1] ? (~num_reg + 1'b1) : num_reg;
                end
            end
            OP_DIV: begin
                if (rem2 >= PROD_W'(den64)) begin
                    rem_reg <= WIDE_W'(rem2 - PROD_W'(den64));
                    q_reg   <= {q_reg[QUO_W-2:0], 1'b1};
                end else begin
                    rem_reg <= WIDE_W'(rem2);
                    q_reg   <= {q_reg[QUO_W-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    // result formatting
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_FINISH) begin
            res_count <= cnt_reg;
            res_ovf   <= drop_reg;
            if (!sts.two_or_more || root_reg == '0) begin
                res_corr  <= '0;
                res_degen <= 1'b1;
            end else begin
                res_degen <= 1'b0;
                if (neg_reg)            res_corr <= 16'(17'h10000 - 17'(q_reg));
                else if (q_reg[15])     res_corr <= 16'sh7FFF;
                else                    res_corr <= 16'(q_reg);
            end
        end
    end

endmodule

>>> rtl/pce_ctrl.sv
// Controller: sequences accumulation, wide products, root, divide and result.
module pce_ctrl
    import pce_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     s_last,
    output logic     m_valid,
    input  logic     m_ready,
    input  pce_sts_t sts,
    output logic     acc_en,
    output logic     clear,
    output pce_cmd_t cmd
);

    typedef enum logic [6:0] {
        ST_ACC  = 7'b0000001,
        ST_MUL  = 7'b0000010,
        ST_WAIT = 7'b0000100,
        ST_ROOT = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_FIN  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       out_reg, out_next;

    assign s_ready = (state_reg == ST_ACC) && !out_reg;
    assign m_valid = out_reg;
    assign acc_en  = s_valid && s_ready;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        out_next   = out_reg && !m_ready;
        clear      = 1'b0;
        cmd.op     = OP_NONE;
        cmd.step   = cnt_reg[4:0];
        cmd.bit_idx = cnt_reg;
        unique case (state_reg)
            ST_ACC: begin
                if (acc_en && s_last) begin
                    state_next = ST_MUL;
                    cnt_next   = '0;
                end
            end
            ST_MUL: begin
                cmd.op   = OP_TERM;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd27) state_next = ST_WAIT;
            end
            ST_WAIT: begin
                // fewer than two pairs: result is degenerate, skip root and divide
                cmd.op     = OP_INIT_R;
                cnt_next   = 6'd62;
                state_next = sts.two_or_more ? ST_ROOT : ST_FIN;
            end
            ST_ROOT: begin
                cmd.op   = OP_ROOT;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0) begin
                    state_next = ST_DIV;
                    cnt_next   = 6'd16;
                end
            end
            ST_DIV: begin
                cmd.op   = (cnt_reg == 6'd16) ? OP_INIT_D : OP_DIV;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.op     = OP_FINISH;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                clear      = 1'b1;
                out_next   = 1'b1;
                state_next = ST_ACC;
            end
            default: state_next = ST_ACC;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACC;
            cnt_reg   <= '0;
            out_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            out_reg   <= out_next;
        end
    end

endmodule

>>> rtl/pce_checker.sv
// Port-level checker for the Pearson correlation engine, bound to the top level.
module pce_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_last,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_correlation,
    input logic        m_degenerate
);

    // a stalled result stays valid with a stable correlation
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_correlation))
        else $error("result dropped or changed while stalled");

    // no input is taken while a result is pending
    a_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken with result pending");

    // after a last request, input closes
    a_close: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last |=> !s_ready)
        else $error("input open after last request");

    // degenerate results carry zero
    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_correlation == 16'd0)
        else $error("degenerate result not zero");

endmodule

bind pearson_correlation_engine pce_checker u_pce_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .s_last, .m_valid, .m_ready,
    .m_correlation, .m_degenerate
);

>>> tb/sv/tb_top.sv
// Self-checking testbench for the Pearson correlation engine.
`timescale 1ns / 100ps

module tb_top;
    import pce_pkg::*;

    localparam int MAX_PAIRS = 65536;
    localparam int PAIR_GAP  = 150;   // covers one result sequence, with margin

    typedef struct {
        logic signed [15:0] corr;
        logic               degen;
        logic [16:0]        count;
        logic               ovf;
    } corr_result_t;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
        logic               has_exp;
        logic signed [15:0] corr;
        logic               degen;
        logic [16:0]        count;
        logic               ovf;
    } stim_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_sample_x;
    logic signed [15:0] s_sample_y;
    logic               s_last;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_correlation;
    logic               m_degenerate;
    logic [16:0]        m_sample_count;
    logic               m_overflow;

    pearson_correlation_engine u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_x    (s_sample_x),
        .s_sample_y    (s_sample_y),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_correlation (m_correlation),
        .m_degenerate  (m_degenerate),
        .m_sample_count(m_sample_count),
        .m_overflow    (m_overflow)
    );

    // Clock: 12 ns period
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Predictor state: exact series sums
    logic [16:0]        pair_cnt;
    logic signed [32:0] acc_x, acc_y;
    logic [46:0]        acc_xx, acc_yy;
    logic signed [47:0] acc_xy;
    logic               dropped;

    corr_result_t expected_q[$];
    corr_result_t typed_q[$];
    logic         typed_valid_q[$];
    int           error_count = 0;
    int           result_count = 0;
    int           series_count = 0;
    int           degen_count = 0;
    bit           rx_hold = 1'b0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic void clear_sums();
        pair_cnt = '0;
        acc_x = '0;
        acc_y = '0;
        acc_xx = '0;
        acc_yy = '0;
        acc_xy = '0;
        dropped = 1'b0;
    endfunction

    // floor(sqrt(v)) for v below 2^126
    function automatic logic [62:0] floor_root(input logic [127:0] v);
        logic [62:0]  r;
        logic [62:0]  c;
        logic [127:0] sq;
        r = '0;
        for (int b = 62; b >= 0; b--) begin
            c = r | (63'd1 << b);
            sq = 128'(c) * 128'(c);
            if (sq <= v)
                r = c;
        end
        return r;
    endfunction

    // Accumulate one pair; returns 1 with the result when the pair closes a series
    function automatic bit predict_pair(input logic signed [15:0] x,
                                        input logic signed [15:0] y,
                                        input logic last, output corr_result_t res);
        logic signed [63:0] n, vx, vy, num;
        logic [63:0]        mag;
        logic [127:0]       prod;
        logic [62:0]        den;
        logic [63:0]        q;
        if (pair_cnt < MAX_PAIRS) begin
            pair_cnt = pair_cnt + 17'd1;
            acc_x  = acc_x + x;
            acc_y  = acc_y + y;
            acc_xx = acc_xx + 47'(32'(x) * 32'(x));
            acc_yy = acc_yy + 47'(32'(y) * 32'(y));
            acc_xy = acc_xy + 48'(32'(x) * 32'(y));
        end else begin
            dropped = 1'b1;
        end
        if (!last)
            return 1'b0;
        res.corr = '0;
        res.degen = 1'b0;
        res.count = pair_cnt;
        res.ovf = dropped;
        n = 64'(pair_cnt);
        if (pair_cnt < 2) begin
            res.degen = 1'b1;
        end else begin
            vx  = n * 64'(acc_xx) - 64'(acc_x) * 64'(acc_x);
            vy  = n * 64'(acc_yy) - 64'(acc_y) * 64'(acc_y);
            num = n * 64'(acc_xy) - 64'(acc_x) * 64'(acc_y);
            prod = 128'(unsigned'(vx)) * 128'(unsigned'(vy));
            den = floor_root(prod);
            if (den == 0) begin
                res.degen = 1'b1;
            end else begin
                mag = (num < 0) ? 64'(-num) : 64'(num);
                q = (128'(mag) << 15) / 128'(den);
                if (num < 0)
                    res.corr = 16'(17'h10000 - 17'(q));
                else
                    res.corr = (q > 32767) ? 16'sd32767 : 16'(q);
            end
        end
        clear_sums();
        return 1'b1;
    endfunction

    // Directed table: extremes, short series and special cases
    localparam int N_DIR = 23;
    stim_row_t dir_rows[N_DIR];

    function automatic stim_row_t mk(input int x, input int y, input bit l);
        stim_row_t r;
        r.x = 16'(x);
        r.y = 16'(y);
        r.last = l;
        r.has_exp = 1'b0;
        r.corr = '0;
        r.degen = 1'b0;
        r.count = '0;
        r.ovf = 1'b0;
        return r;
    endfunction

    function automatic stim_row_t mk_exp(input int x, input int y, input int c,
                                         input bit d, input int cnt);
        stim_row_t r;
        r = mk(x, y, 1'b1);
        r.has_exp = 1'b1;
        r.corr = 16'(c);
        r.degen = d;
        r.count = 17'(cnt);
        return r;
    endfunction

    initial begin
        // single pair after reset: too few pairs
        dir_rows[0]  = mk_exp(32767, -32768, 0, 1, 1);
        // perfect positive correlation at full scale
        dir_rows[1]  = mk(-32768, -32768, 0);
        dir_rows[2]  = mk_exp(32767, 32767, 32767, 0, 2);
        // perfect negative correlation
        dir_rows[3]  = mk(-32768, 32767, 0);
        dir_rows[4]  = mk_exp(32767, -32768, -32768, 0, 2);
        // zero variance in x
        dir_rows[5]  = mk(5, 1, 0);
        dir_rows[6]  = mk(5, -9, 0);
        dir_rows[7]  = mk_exp(5, 300, 0, 1, 3);
        // zero variance in y
        dir_rows[8]  = mk(-1, -32768, 0);
        dir_rows[9]  = mk_exp(0, -32768, 0, 1, 2);
        // all zero
        dir_rows[10] = mk(0, 0, 0);
        dir_rows[11] = mk_exp(0, 0, 0, 1, 2);
        // three small mixed series, checked by the predictor
        dir_rows[12] = mk(1, 2, 0);
        dir_rows[13] = mk(2, 1, 0);
        dir_rows[14] = mk(3, 4, 0);
        dir_rows[15] = mk(-32768, 100, 0);
        dir_rows[16] = mk(21845, -21846, 1);
        dir_rows[17] = mk(-1, 1, 0);
        dir_rows[18] = mk(1, -1, 0);
        dir_rows[19] = mk(-21846, 21845, 0);
        dir_rows[20] = mk(32767, 0, 1);
        dir_rows[21] = mk(255, 256, 0);
        dir_rows[22] = mk(-256, 1000, 1);
    end

    // Offer one request and wait for it to be taken; valid stays up for the next one
    task automatic send_pair(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic last, input bit has_exp, input corr_result_t want);
        corr_result_t res;
        s_sample_x <= x;
        s_sample_y <= y;
        s_last <= last;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (predict_pair(x, y, last, res)) begin
            expected_q.insert(expected_q.size(), res);
            typed_q.insert(typed_q.size(), want);
            typed_valid_q.insert(typed_valid_q.size(), has_exp);
            series_count++;
        end
        @(negedge aclk);
    endtask

    // Drop valid and idle the input; n sets the length of the spell
    task automatic idle_cycles(input int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do
            @(negedge aclk);
        while (expected_q.size() != 0);
    endtask

    // Random series of len pairs; mode sets how y follows x, gaps adds idle spells
    task automatic run_series(input int len, input int mode, input bit gaps);
        logic signed [15:0] x, y;
        corr_result_t none;
        int pick;
        none = '{default: '0};
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            x = 16'($urandom);
            case (mode)
                0: y = 16'($urandom);
                1: y = x + 16'($urandom_range(0, 2000)) - 16'sd1000;
                2: y = -x + 16'($urandom_range(0, 63));
                default: y = (pick < 50) ? x : 16'($urandom_range(0, 3));
            endcase
            if (pick < 8) x = (pick < 4) ? 16'sh8000 : 16'sh7FFF;
            send_pair(x, y, (i == len - 1), 1'b0, none);
            if (gaps && $urandom_range(0, 3) == 0)
                idle_cycles($urandom_range(1, 13));
        end
    endtask

    // Result checking at the rising edge
    always @(posedge aclk) begin
        corr_result_t want;
        corr_result_t typed;
        bit typed_ok;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", m_correlation, 0);
            end else begin
                want = expected_q.pop_front();
                typed = typed_q.pop_front();
                typed_ok = typed_valid_q.pop_front();
                result_count++;
                if (m_degenerate) degen_count++;
                if (m_correlation !== want.corr)
                    report_mismatch("correlation", m_correlation, want.corr);
                if (m_degenerate !== want.degen)
                    report_mismatch("degenerate", m_degenerate, want.degen);
                if (m_sample_count !== want.count)
                    report_mismatch("sample_count", m_sample_count, want.count);
                if (m_overflow !== want.ovf)
                    report_mismatch("overflow", m_overflow, want.ovf);
                if (typed_ok && (typed.corr !== want.corr || typed.degen !== want.degen
                                 || typed.count !== want.count))
                    report_mismatch("table entry vs predictor", want.corr, typed.corr);
            end
        end
    end

    // Receiver: random stalls, and a long hold-off on request
    initial begin
        int wait_n;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (rx_hold) begin
                m_ready <= 1'b0;
                repeat (400) @(negedge aclk);
                rx_hold = 1'b0;
            end
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (wait_n > 0) begin
                m_ready <= 1'b0;
                repeat (wait_n) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Stimulus and end of run
    initial begin
        corr_result_t typed;
        int items;
        int len;
        s_valid = 1'b0;
        s_sample_x = '0;
        s_sample_y = '0;
        s_last = 1'b0;
        aresetn = 1'b0;
        clear_sums();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < N_DIR; i++) begin
            typed.corr = dir_rows[i].corr;
            typed.degen = dir_rows[i].degen;
            typed.count = dir_rows[i].count;
            typed.ovf = dir_rows[i].ovf;
            send_pair(dir_rows[i].x, dir_rows[i].y, dir_rows[i].last,
                      dir_rows[i].has_exp, typed);
        end

        // long receiver hold-off while series keep coming
        rx_hold = 1'b1;
        for (int i = 0; i < 6; i++)
            run_series(3, i % 4, 1'b0);

        // sender pauses until everything has drained
        drain_results();
        idle_cycles(PAIR_GAP);

        items = 0;
        while (items < 1900) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 200)
                                               : $urandom_range(1, 12);
            run_series(len, $urandom_range(0, 3), ($urandom_range(0, 2) != 0));
            items += len;
        end

        drain_results();
        idle_cycles(PAIR_GAP);
        $display("Covered %0d series with %0d results checked (%0d degenerate),",
                 series_count, result_count, degen_count);
        $display("including full-scale, zero-variance, single-pair and stall cases.");
        if (error_count == 0 && expected_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Timeout guard
    initial begin
        #20ms;
        $display("Timeout with %0d results still pending", expected_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
